// ----- rtl/pkdbf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Per-key deadband change filter: shared package
// Widths, slot count, search token, write-back bundle and controller states.
// ----------------------------------------------------------------------------
package pkdbf_pkg;

  // Table geometry
  localparam int SLOTS        = 8;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W        = 32;
  localparam int AMP_W        = 16;
  localparam int SLOT_FIELD_W = 3;

  // Deadband after reset: 0.03 in unsigned Q1.15
  localparam logic [AMP_W-1:0] DEADBAND_RESET = 16'd983;

  // Search token handed from cell to cell
  typedef struct packed {
    logic              active;
    logic [KEY_W-1:0]  key;
    logic [AMP_W-1:0]  amp;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [AMP_W-1:0]  hit_amp;
    logic              free;
    logic [SLOT_W-1:0] free_idx;
  } token_t;

  // Write-back broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [KEY_W-1:0]  key;
    logic [AMP_W-1:0]  amp;
  } slot_wr_t;

  // One result item
  typedef struct packed {
    logic                    report;
    logic                    new_key;
    logic [SLOT_FIELD_W-1:0] slot_used;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

endpackage : pkdbf_pkg
`default_nettype wire

// ----- rtl/pkdbf_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Per-key deadband change filter: table cell
// Holds one slot (key, amplitude, valid) and updates the passing search token.
// ----------------------------------------------------------------------------
module pkdbf_cell (
  input  wire                        clk,
  input  wire                        rst,
  input  wire  [pkdbf_pkg::SLOT_W-1:0] cell_idx,
  input  wire  pkdbf_pkg::token_t    tok_in,
  output pkdbf_pkg::token_t          tok_out,
  input  wire  pkdbf_pkg::slot_wr_t  wr
);
  import pkdbf_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic [AMP_W-1:0] amp_q;
  logic             valid_q;
  token_t           tok_next;
  logic             match;

  // Compare the passing key against this slot
  always_comb begin
    match    = valid_q && (key_q == tok_in.key);
    tok_next = tok_in;
    if (!tok_in.hit && match) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = cell_idx;
      tok_next.hit_amp = amp_q;
    end
    if (!tok_in.hit && !valid_q && !tok_in.free) begin
      tok_next.free     = 1'b1;
      tok_next.free_idx = cell_idx;
    end
  end

  // Hand the token on to the neighbour
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // Slot storage, written by the broadcast write-back
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      key_q <= wr.key;
      amp_q <= wr.amp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (wr.en && (wr.idx == cell_idx)) begin
      valid_q <= 1'b1;
    end
  end

endmodule : pkdbf_cell
`default_nettype wire

// ----- rtl/pkdbf_eval.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Per-key deadband change filter: decision and output register
// Applies the deadband test to the token leaving the chain, drives the
// write-back and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module pkdbf_eval (
  input  wire                       clk,
  input  wire                       rst,
  input  wire  pkdbf_pkg::token_t   tok_end,
  input  wire  [pkdbf_pkg::AMP_W-1:0] deadband,
  input  wire                       out_ready,
  output pkdbf_pkg::slot_wr_t       wr,
  output logic                      out_valid,
  output pkdbf_pkg::result_t        out_result
);
  import pkdbf_pkg::*;

  logic [AMP_W-1:0]  diff;
  logic [SLOT_W-1:0] slot_idx;
  logic              report;
  result_t           result_next;

  // Absolute difference, slot choice and report decision
  always_comb begin
    diff     = (tok_end.amp > tok_end.hit_amp) ? (tok_end.amp - tok_end.hit_amp)
                                               : (tok_end.hit_amp - tok_end.amp);
    if (tok_end.hit) begin
      slot_idx = tok_end.hit_idx;
      report   = (diff >= deadband);
    end else begin
      slot_idx = tok_end.free ? tok_end.free_idx : '0;
      report   = 1'b1;
    end
    result_next.report    = report;
    result_next.new_key   = !tok_end.hit;
    result_next.slot_used = SLOT_FIELD_W'(slot_idx);

    wr.en  = tok_end.active && report;
    wr.idx = slot_idx;
    wr.key = tok_end.key;
    wr.amp = tok_end.amp;
  end

  // Output register: load on a finished search, drop on a transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tok_end.active) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_end.active) begin
      out_result <= result_next;
    end
  end

endmodule : pkdbf_eval
`default_nettype wire

// ----- rtl/per_key_deadband_change_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Per-key deadband change filter: top level
// Only one item is in flight: a new item is accepted only after its search
//   token has passed the whole slot chain, visiting one cell of the chain per
//   cycle, and the output register is free.
// Reset: rst (synchronous, active high) clears all slot valid marks, the
//   controller and the output valid flag, and sets the deadband to 983.
// ----------------------------------------------------------------------------
module per_key_deadband_change_filter (
  input  wire         clk,
  input  wire         rst,
  // Input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,  // key[31:0], amp_lo_band[47:32], amp_hi_band[63:48]
  // Result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // report[0], new_key[1], slot_used[4:2], zero[7:5]
  // Deadband register write
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data
);
  import pkdbf_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [AMP_W-1:0]  deadband;
  logic              in_accept;
  logic [AMP_W-1:0]  amp_lo;
  logic [AMP_W-1:0]  amp_hi;
  token_t            tok [SLOTS+1];
  slot_wr_t          wr;
  result_t           result;
  logic [SLOTS:0]    act_vec;

  // Deadband register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= DEADBAND_RESET;
    end else if (cfg_valid) begin
      deadband <= cfg_data;
    end
  end

  // Controller state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accept only when idle and the output register will be free
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = !m_axis_tvalid || m_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok[SLOTS].active) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Launch the search token with the larger amplitude
  always_comb begin
    amp_lo          = s_axis_tdata[47:32];
    amp_hi          = s_axis_tdata[63:48];
    tok[0].active   = in_accept;
    tok[0].key      = s_axis_tdata[31:0];
    tok[0].amp      = (amp_lo > amp_hi) ? amp_lo : amp_hi;
    tok[0].hit      = 1'b0;
    tok[0].hit_idx  = '0;
    tok[0].hit_amp  = '0;
    tok[0].free     = 1'b0;
    tok[0].free_idx = '0;
  end

  // Chain of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    pkdbf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (SLOT_W'(i)),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .wr       (wr)
    );
  end

  // Decision, write-back and output register
  pkdbf_eval u_eval (
    .clk        (clk),
    .rst        (rst),
    .tok_end    (tok[SLOTS]),
    .deadband   (deadband),
    .out_ready  (m_axis_tready),
    .wr         (wr),
    .out_valid  (m_axis_tvalid),
    .out_result (result)
  );

  assign m_axis_tdata = {3'b000, result.slot_used, result.new_key, result.report};

  // Token activity along the chain, for checking
  always_comb begin
    for (int j = 0; j <= SLOTS; j++) begin
      act_vec[j] = tok[j].active;
    end
  end

`ifndef SYNTHESIS
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(act_vec))
    else $error("more than one search token in the chain");

  a_token_in_search: assert property (@(posedge clk) disable iff (rst)
    tok[SLOTS].active |-> (state == ST_SEARCH))
    else $error("search finished while the controller was idle");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    tok[SLOTS].active |-> !m_axis_tvalid)
    else $error("result loaded while the previous one was still pending");
`endif

endmodule : per_key_deadband_change_filter
`default_nettype wire

// ----- bench/tb_per_key_deadband_change_filter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Per-key deadband change filter: testbench
// Drives key/amplitude items into the input stream and checks every result
// against a local model of the slot table. The deadband register is
// rewritten between phases while the block is idle. Directed items cover
// field extremes and table corners. Random phases then use small key pools,
// so that hits, misses and slot 0 overwrites all occur. Both stream sides
// idle at random, and one phase holds the result side off for a long time.
// ----------------------------------------------------------------------------
module tb_per_key_deadband_change_filter;
  import pkdbf_pkg::*;

  localparam int CLK_HALF_NS      = 5;
  localparam int TIMEOUT_NS       = 3_000_000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS      = 150;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // key[31:0], amp_lo_band[47:32], amp_hi_band[63:48]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // report[0], new_key[1], slot_used[4:2], zero[7:5]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // Local copy of the slot table and the deadband
  logic [KEY_W-1:0] tbl_key   [SLOTS];
  logic [AMP_W-1:0] tbl_amp   [SLOTS];
  bit               tbl_valid [SLOTS];
  logic [AMP_W-1:0] cur_deadband;

  result_t          expected_results [$];
  logic [KEY_W-1:0] key_pool [$];
  int               fail_count = 0;

  // Pacing controls shared between the test tasks and the two stream sides
  bit src_gaps_on       = 1'b1;
  int burst_left        = 0;
  bit sink_eager        = 1'b0;
  bit long_hold_pending = 1'b0;

  per_key_deadband_change_filter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // Clear the table and restore the deadband, as reset does
  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_key[i]   = '0;
      tbl_amp[i]   = '0;
      tbl_valid[i] = 1'b0;
    end
    cur_deadband = DEADBAND_RESET;
  endfunction

  // Look the key up, place or refresh it, and return the expected result
  function automatic result_t filter_item(input logic [KEY_W-1:0] key,
                                          input logic [AMP_W-1:0] lo,
                                          input logic [AMP_W-1:0] hi);
    result_t          r;
    logic [AMP_W-1:0] amp;
    logic [AMP_W-1:0] diff;
    int               hit;
    int               free_idx;
    int               slot;
    amp      = (lo > hi) ? lo : hi;
    hit      = -1;
    free_idx = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0) begin
        if (tbl_valid[i] && tbl_key[i] == key) begin
          hit = i;
        end else if (!tbl_valid[i] && free_idx < 0) begin
          free_idx = i;
        end
      end
    end
    if (hit < 0) begin
      // Miss: take the lowest free slot, or overwrite slot 0 when full
      slot            = (free_idx >= 0) ? free_idx : 0;
      tbl_valid[slot] = 1'b1;
      tbl_key[slot]   = key;
      tbl_amp[slot]   = amp;
      r.report        = 1'b1;
      r.new_key       = 1'b1;
    end else begin
      slot      = hit;
      diff      = (amp > tbl_amp[hit]) ? amp - tbl_amp[hit] : tbl_amp[hit] - amp;
      r.new_key = 1'b0;
      if (diff < cur_deadband) begin
        r.report = 1'b0;
      end else begin
        tbl_amp[hit] = amp;
        r.report     = 1'b1;
      end
    end
    r.slot_used = slot[SLOT_FIELD_W-1:0];
    return r;
  endfunction

  // Stored amplitude of a tracked key, used to aim items at the deadband edge
  function automatic bit lookup_amp(input logic [KEY_W-1:0] key,
                                    output logic [AMP_W-1:0] amp);
    bit found;
    found = 1'b0;
    amp   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && tbl_valid[i] && tbl_key[i] == key) begin
        found = 1'b1;
        amp   = tbl_amp[i];
      end
    end
    return found;
  endfunction

  // Compare one result transaction with the oldest expectation
  task automatic check_result(input logic [7:0] d);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result 0x%02h arrived with nothing expected", d);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      if (d[0] !== want.report) begin
        $error("report: expected %0d, got %0d", want.report, d[0]);
        fail_count++;
      end
      if (d[1] !== want.new_key) begin
        $error("new_key: expected %0d, got %0d", want.new_key, d[1]);
        fail_count++;
      end
      if (d[4:2] !== want.slot_used) begin
        $error("slot_used: expected %0d, got %0d", want.slot_used, d[4:2]);
        fail_count++;
      end
      if (d[7:5] !== 3'b000) begin
        $error("pad: expected 0, got %0d", d[7:5]);
        fail_count++;
      end
    end
  endtask

  // Track register writes, check results, predict accepted items
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) cur_deadband = cfg_data;
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(filter_item(s_axis_tdata[31:0], s_axis_tdata[47:32],
                                               s_axis_tdata[63:48]));
      end
    end
  end

  // Result side: long hold on request, else always ready or a stall pattern
  initial begin : sink_pacing
    int sink_left;
    bit ready_phase;
    sink_left     = 0;
    ready_phase   = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
        long_hold_pending = 1'b0;
      end else if (sink_eager) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (sink_left == 0) begin
          ready_phase = !ready_phase;
          sink_left   = ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end
        sink_left--;
        m_axis_tready <= ready_phase;
      end
    end
  end

  // Offer one item and hold it until accepted; valid stays high within a burst
  task automatic send_item(input logic [KEY_W-1:0] key, input logic [AMP_W-1:0] lo,
                           input logic [AMP_W-1:0] hi);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo, key};
    do @(posedge clk); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (src_gaps_on) begin
        gap = $urandom_range(1, 10);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every result is in and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  task automatic write_deadband(input logic [AMP_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Pick a key, mostly from the pool, and an amplitude, often near the deadband edge
  task automatic send_random_item();
    logic [KEY_W-1:0] key;
    logic [AMP_W-1:0] stored;
    logic [AMP_W-1:0] target;
    logic [AMP_W-1:0] other;
    int               sel;
    int               jitter;
    int               level;
    sel = $urandom_range(0, 99);
    if (sel < 8) key = $urandom();
    else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    sel = $urandom_range(0, 99);
    if (lookup_amp(key, stored) && sel < 60) begin
      jitter = $urandom_range(0, 4);
      level  = int'(cur_deadband) + jitter - 2;
      if ($urandom_range(0, 1)) level = -level;
      level = level + int'(stored);
      if (level < 0) level = 0;
      if (level > 65535) level = 65535;
      target = level[15:0];
    end else if (sel < 85) begin
      target = 16'($urandom_range(0, 32768));
    end else begin
      target = 16'($urandom_range(0, 65535));
    end
    other = 16'($urandom_range(0, target));
    if ($urandom_range(0, 1)) send_item(key, target, other);
    else send_item(key, other, target);
  endtask

  // Field extremes, deadband boundary at reset value, table fill and overwrite
  task automatic test_directed_edges();
    send_item(32'h0000_0000, 16'd0, 16'd0);
    send_item(32'hFFFF_FFFF, 16'd32768, 16'd0);
    send_item(32'h0000_0000, 16'd982, 16'd0);      // one below the deadband: quiet
    send_item(32'h0000_0000, 16'd0, 16'd983);      // exactly the deadband: report
    send_item(32'hFFFF_FFFF, 16'd0, 16'd0);
    send_item(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);  // above full scale, not clipped
    send_item(32'hFFFF_FFFF, 16'd1, 16'hFFFF);     // no change
    send_item(32'hA5A5_A5A5, 16'd100, 16'd7);
    send_item(32'h5A5A_5A5A, 16'd3, 16'd20000);
    send_item(32'h0000_0001, 16'h5555, 16'h2AAA);
    send_item(32'h8000_0000, 16'h2AAA, 16'h5555);
    send_item(32'h1234_5678, 16'd32767, 16'd32768);
    send_item(32'h0000_FFFF, 16'd1, 16'd1);
    send_item(32'hDEAD_BEEF, 16'd500, 16'd400);    // table full: slot 0 overwritten
    send_item(32'h0000_0000, 16'd0, 16'd0);        // evicted key returns as new
    send_item(32'h8000_0000, 16'h2AAA, 16'h5555);
    send_item(32'hFFFF_0000, 16'h8000, 16'h7FFF);
  endtask

  // Zero deadband reports every known key; all-ones and half scale
  task automatic test_deadband_extremes();
    write_deadband(16'd0);
    send_item(32'hFFFF_FFFF, 16'hFFFF, 16'd0);
    send_item(32'h8000_0000, 16'h2AAA, 16'h5555);
    send_item(32'h0000_0001, 16'h5555, 16'd0);
    write_deadband(16'hFFFF);
    send_item(32'hFFFF_FFFF, 16'd0, 16'd0);
    send_item(32'hFFFF_FFFF, 16'hFFFF, 16'd0);
    send_item(32'hFFFF_FFFF, 16'd0, 16'd1);
    write_deadband(16'd32768);
    send_item(32'h0000_0001, 16'd0, 16'd0);
    send_item(32'h0000_0001, 16'd32768, 16'd0);
    send_item(32'h0000_0001, 16'd1, 16'd0);
  endtask

  // Random phases over several deadband settings and key pool sizes
  task automatic test_random_phases();
    logic [AMP_W-1:0] db_list [7];
    int               n_keys;
    db_list = '{16'd983, 16'd1, 16'd0, 16'd32768, 16'hFFFF,
                16'($urandom_range(0, 65535)), 16'($urandom_range(2, 3000))};
    for (int p = 0; p < 7; p++) begin
      write_deadband(db_list[p]);
      // first phase runs with no idling on either side
      src_gaps_on = (p != 0);
      sink_eager  = (p == 0) || ($urandom_range(0, 3) == 0);
      n_keys      = $urandom_range(4, 14);
      key_pool.delete();
      key_pool.push_back(32'h0000_0000);
      key_pool.push_back(32'hFFFF_FFFF);
      for (int k = 2; k < n_keys; k++) key_pool.push_back($urandom());
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
    end
    src_gaps_on = 1'b1;
    sink_eager  = 1'b0;
  endtask

  // Hold the result side off while items keep coming, then drain and resume
  task automatic test_long_stall();
    write_deadband(16'($urandom_range(0, 2000)));
    src_gaps_on       = 1'b0;
    long_hold_pending = 1'b1;
    for (int n = 0; n < 20; n++) send_random_item();
    src_gaps_on = 1'b1;
    wait_idle();
    for (int n = 0; n < 20; n++) send_random_item();
  endtask

  initial begin : run
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    clear_table();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_deadband_extremes();
    test_random_phases();
    test_long_stall();

    wait_idle();
    repeat (4 * (SLOTS + 1)) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pkdbf_pkg.sv
rtl/pkdbf_cell.sv
rtl/pkdbf_eval.sv
rtl/per_key_deadband_change_filter.sv
bench/tb_per_key_deadband_change_filter.sv
